/* rtl/bst_pkg.sv */
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and constants for the bounded set table.
// ----------------------------------------------------------------------------
`default_nettype none

package bst_pkg;

  localparam int unsigned SetDepthDef = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned CountW      = 5;
  localparam int unsigned StatusW     = 3;

  // Operation codes carried on the input tuser bit.
  localparam logic FuncInsert = 1'b0;
  localparam logic FuncDelete = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StInserted = 3'd0,
    StPresent  = 3'd1,
    StFull     = 3'd2,
    StDeleted  = 3'd3,
    StMissing  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StExec,
    StShift,
    StDone
  } state_e;

  // Control from the sequencer to the scan accumulator.
  typedef struct packed {
    logic clear;   // start of a new scan
    logic sample;  // read data of a held entry is valid this cycle
  } scan_ctl_t;

endpackage : bst_pkg

`default_nettype wire

/* rtl/bst_ram.sv */
// ----------------------------------------------------------------------------
// bst_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : bst_ram

`default_nettype wire

/* rtl/bst_scan.sv */
// ----------------------------------------------------------------------------
// bst_scan
// Match search and min/max accumulation over entries streamed from memory.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_scan #(
  parameter int unsigned AddrW = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire bst_pkg::scan_ctl_t              ctl_i,
  input  wire logic signed [bst_pkg::DataW-1:0] key_i,
  input  wire logic signed [bst_pkg::DataW-1:0] data_i,
  input  wire logic [AddrW-1:0]                idx_i,
  output logic                                 found_o,
  output logic [AddrW-1:0]                     pos_o,
  output logic                                 any_o,
  output logic signed [bst_pkg::DataW-1:0]     lo_o,
  output logic signed [bst_pkg::DataW-1:0]     hi_o
);
  import bst_pkg::*;

  logic                    found_q, found_d;
  logic                    any_q, any_d;
  logic [AddrW-1:0]        pos_q, pos_d;
  logic signed [DataW-1:0] lo_q, lo_d, hi_q, hi_d;

  // Entries equal to the key are left out of min/max: the set holds each
  // value once, so this is exactly the entry a delete removes.
  always_comb begin
    found_d = found_q;
    any_d   = any_q;
    pos_d   = pos_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    if (ctl_i.clear) begin
      found_d = 1'b0;
      any_d   = 1'b0;
    end else if (ctl_i.sample) begin
      if (data_i == key_i) begin
        if (!found_q) begin
          found_d = 1'b1;
          pos_d   = idx_i;
        end
      end else begin
        any_d = 1'b1;
        if (!any_q || (data_i < lo_q)) lo_d = data_i;
        if (!any_q || (data_i > hi_q)) hi_d = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      any_q   <= 1'b0;
    end else begin
      found_q <= found_d;
      any_q   <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
  end

  assign found_o = found_q;
  assign pos_o   = pos_q;
  assign any_o   = any_q;
  assign lo_o    = lo_q;
  assign hi_o    = hi_q;

endmodule : bst_scan

`default_nettype wire

/* rtl/bounded_set_table_core.sv */
// ----------------------------------------------------------------------------
// bounded_set_table_core
// Each item walks the held entries through the one read port of the entry
// memory to search them; a delete that hits walks them again to close the gap.
// A new item is taken only once the last one is done, but it is taken while
// the result still waits in the output register.
// Reset clears the fill count and all control; the entry memory is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_set_table_core #(
  parameter int unsigned SET_DEPTH = bst_pkg::SetDepthDef,
  localparam int unsigned AddrW = $clog2(SET_DEPTH),
  localparam int unsigned CntW  = $clog2(SET_DEPTH + 1)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] func
  // Result items.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o,   // [4:0] count, [5] is_empty,
                                             // [37:6] min_value,
                                             // [69:38] max_value, [71:70] zero
  output logic [2:0]       m_axis_tuser_o    // [2:0] status
);
  import bst_pkg::*;

  // Sequencer state and item registers.
  state_e                  state_q, state_d;
  logic [CntW-1:0]         fill_q, fill_d;
  logic [CntW-1:0]         cnt_q, cnt_d;      // read pointer of a memory walk
  logic [AddrW-1:0]        ridx_q;            // address of the read in flight
  logic                    rvalid_q;          // read data valid this cycle
  logic                    func_q;
  logic signed [DataW-1:0] key_q;

  // Result held between decision and delivery.
  status_e                 res_status_q, res_status_d;
  logic [CntW-1:0]         res_fill_q, res_fill_d;
  logic signed [DataW-1:0] res_lo_q, res_lo_d, res_hi_q, res_hi_d;

  // Output register.
  logic                    out_valid_q;
  status_e                 out_status_q;
  logic [CountW-1:0]       out_count_q;
  logic                    out_empty_q;
  logic signed [DataW-1:0] out_lo_q, out_hi_q;

  // Sequencer outputs.
  logic                    in_ready;
  logic                    rd_en, wr_en, load_out;
  logic [AddrW-1:0]        rd_addr, wr_addr;
  logic [DataW-1:0]        wr_data;
  scan_ctl_t               scan_ctl;

  // Memory and scan unit signals.
  logic [DataW-1:0]        rdata;
  logic                    found, any_held;
  logic [AddrW-1:0]        pos;
  logic signed [DataW-1:0] scan_lo, scan_hi;

  logic in_acc, out_free, walk_done;

  assign in_acc   = s_axis_tvalid_i && in_ready;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // The search walk reads entries 0 .. fill-1; the shift walk reads from
  // the entry after the match up to the last held one.
  always_comb begin
    rd_en = 1'b0;
    case (state_q)
      StScan:  rd_en = (cnt_q < fill_q);
      StShift: rd_en = (cnt_q <= fill_q);
      default: rd_en = 1'b0;
    endcase
  end
  assign rd_addr   = cnt_q[AddrW-1:0];
  assign walk_done = !rd_en && !rvalid_q;

  // Decision, once the search is complete.
  logic is_insert, is_full, do_ins, do_del, incl_key;
  logic signed [DataW-1:0] lo_x, hi_x;

  always_comb begin
    is_insert = (func_q == FuncInsert);
    is_full   = (fill_q == CntW'(SET_DEPTH));
    do_ins    = is_insert && !found && !is_full;
    do_del    = !is_insert && found;
    // The key belongs to the resulting set when it was held or just added.
    incl_key  = is_insert && (found || !is_full);
    lo_x      = scan_lo;
    hi_x      = scan_hi;
    if (incl_key) begin
      if (!any_held || (key_q < scan_lo)) lo_x = key_q;
      if (!any_held || (key_q > scan_hi)) hi_x = key_q;
    end else if (!any_held) begin
      lo_x = '0;
      hi_x = '0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_acc) state_d = StScan;
      StScan:  if (walk_done) state_d = StExec;
      StExec:  state_d = do_del ? StShift : StDone;
      StShift: if (walk_done) state_d = StDone;
      StDone:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready       = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = rdata;
    load_out       = 1'b0;
    scan_ctl.clear  = 1'b0;
    scan_ctl.sample = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready       = 1'b1;
        scan_ctl.clear = 1'b1;
      end
      StScan: begin
        scan_ctl.sample = rvalid_q;
      end
      StExec: begin
        wr_en   = do_ins;
        wr_addr = fill_q[AddrW-1:0];
        wr_data = key_q;
      end
      StShift: begin
        // Each entry read is written back one place lower.
        wr_en   = rvalid_q;
        wr_addr = ridx_q - AddrW'(1);
        wr_data = rdata;
      end
      StDone: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    fill_d       = fill_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_fill_d   = res_fill_q;
    res_lo_d     = res_lo_q;
    res_hi_d     = res_hi_q;
    if (in_acc) begin
      cnt_d = '0;
    end else if (rd_en) begin
      cnt_d = cnt_q + CntW'(1);
    end
    if (state_q == StExec) begin
      res_lo_d = lo_x;
      res_hi_d = hi_x;
      cnt_d    = CntW'(pos) + CntW'(1);
      if (do_ins) begin
        fill_d       = fill_q + CntW'(1);
        res_status_d = StInserted;
      end else if (do_del) begin
        fill_d       = fill_q - CntW'(1);
        res_status_d = StDeleted;
      end else if (is_insert) begin
        res_status_d = found ? StPresent : StFull;
      end else begin
        res_status_d = StMissing;
      end
      res_fill_d = fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      cnt_q       <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
      rvalid_q <= rd_en;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q       <= rd_addr;
    res_status_q <= res_status_d;
    res_fill_q   <= res_fill_d;
    res_lo_q     <= res_lo_d;
    res_hi_q     <= res_hi_d;
    if (in_acc) begin
      func_q <= s_axis_tuser_i[0];
      key_q  <= s_axis_tdata_i;
    end
    if (load_out) begin
      out_status_q <= res_status_q;
      out_count_q  <= CountW'(res_fill_q);
      out_empty_q  <= (res_fill_q == '0);
      out_lo_q     <= res_lo_q;
      out_hi_q     <= res_hi_q;
    end
  end

  bst_ram #(
    .Width (DataW),
    .Depth (SET_DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  bst_scan #(
    .AddrW (AddrW)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .key_i   (key_q),
    .data_i  (rdata),
    .idx_i   (ridx_q),
    .found_o (found),
    .pos_o   (pos),
    .any_o   (any_held),
    .lo_o    (scan_lo),
    .hi_o    (scan_hi)
  );

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {2'b00, out_hi_q, out_lo_q, out_empty_q, out_count_q};

`ifndef SYNTH
  // The fill count never runs past the memory depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= CntW'(SET_DEPTH))
    else $error("fill count exceeds set depth");

  // During the shift, the write-back never lands on the entry being read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write collide on one entry");

  // An insert write adds exactly one entry to the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && state_q == StExec) |=> (fill_q == $past(fill_q) + CntW'(1)))
    else $error("insert did not advance the fill count");
`endif

endmodule : bounded_set_table_core

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for bounded_set_table_core. Insert and delete items are sent
// on the input stream. A predictor inside the testbench keeps its own copy
// of the held entries and works out the status, count, empty flag, minimum
// and maximum that each accepted item must return. A checker compares each
// result item, field by field, with the oldest outstanding prediction.
// Both stream sides idle and stall at random, apart from one quiet stretch.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bst_pkg::*;

  localparam int unsigned SetDepth   = SetDepthDef;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PoolSize   = 24;

  // One predicted result item.
  typedef struct packed {
    status_e     status;
    logic [4:0]  count;
    logic        is_empty;
    logic [31:0] min_value;
    logic [31:0] max_value;
  } set_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;   // [31:0] value
  logic [0:0]  s_axis_tuser_i  = '0;   // [0] func
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;         // [4:0] count, [5] is_empty,
                                       // [37:6] min_value, [69:38] max_value
  logic [2:0]  m_axis_tuser_o;         // [2:0] status

  // Predictor state: held entries in insertion order and their number.
  logic signed [31:0] held_vals [SetDepth];
  int unsigned        held_fill = 0;

  set_result_t pending_set_results [$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  // When clear, neither side idles or stalls.
  bit          idle_on     = 1'b1;

  bounded_set_table_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a correct run finishes well inside CycleLimit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // Works out the result of one accepted item and updates the held entries.
  // A delete takes out the first match and moves every later entry down.
  function automatic void predict_set_op(input logic func, input logic [31:0] value);
    set_result_t        res;
    int                 pos;
    int unsigned        i;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    pos = -1;
    for (i = 0; i < held_fill; i++) begin
      if (pos < 0 && held_vals[i] == value) pos = i;
    end
    if (func == FuncInsert) begin
      // A held value is reported as present even when the set is full.
      if (pos >= 0) begin
        res.status = StPresent;
      end else if (held_fill >= SetDepth) begin
        res.status = StFull;
      end else begin
        held_vals[held_fill] = value;
        held_fill++;
        res.status = StInserted;
      end
    end else begin
      if (pos >= 0) begin
        for (i = pos; i + 1 < held_fill; i++) held_vals[i] = held_vals[i + 1];
        held_fill--;
        res.status = StDeleted;
      end else begin
        res.status = StMissing;
      end
    end
    // An empty set reads zero for both bounds.
    lo = '0;
    hi = '0;
    if (held_fill > 0) begin
      lo = held_vals[0];
      hi = held_vals[0];
      for (i = 1; i < held_fill; i++) begin
        if (held_vals[i] < lo) lo = held_vals[i];
        if (held_vals[i] > hi) hi = held_vals[i];
      end
    end
    res.count     = 5'(held_fill);
    res.is_empty  = (held_fill == 0);
    res.min_value = lo;
    res.max_value = hi;
    pending_set_results.push_back(res);
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, fname, want, got);
      fail_count++;
    end
  endfunction

  // Result side: checks each accepted result item and drives a randomly
  // stalling tready. Values read here are those present at the clock edge.
  always @(posedge clk_i) begin : result_checker
    set_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_set_results.size() == 0) begin
        $display("%0t: unexpected result item, actual status %0d data 0x%018h",
                 $time, m_axis_tuser_o, m_axis_tdata_o);
        fail_count++;
      end else begin
        want = pending_set_results.pop_front();
        check_field("status", 32'(want.status), 32'(m_axis_tuser_o));
        check_field("count", 32'(want.count), 32'(m_axis_tdata_o[4:0]));
        check_field("is_empty", 32'(want.is_empty), 32'(m_axis_tdata_o[5]));
        check_field("min_value", want.min_value, m_axis_tdata_o[37:6]);
        check_field("max_value", want.max_value, m_axis_tdata_o[69:38]);
      end
    end
    m_axis_tready_i <= !idle_on || ($urandom_range(99) >= 8);
  end

  // Sends one item and waits for its acceptance. Valid stays high after the
  // handshake so that back-to-back items need no second assignment; it is
  // only lowered when an idle gap is taken.
  task automatic send_set_op(input logic func, input logic [31:0] value);
    if (idle_on && $urandom_range(99) < 8) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 90) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= func;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_set_op(func, value);
  endtask

  // Deleting from the empty set after reset: not found, bounds read zero.
  task automatic test_empty_set();
    send_set_op(FuncDelete, 32'h0000_0000);
  endtask

  // The most negative and most positive values as bounds, then a duplicate.
  task automatic test_extremes_and_dups();
    send_set_op(FuncInsert, 32'h8000_0000);
    send_set_op(FuncInsert, 32'h7FFF_FFFF);
    send_set_op(FuncInsert, 32'h0000_0000);
    send_set_op(FuncInsert, 32'hFFFF_FFFF);
    send_set_op(FuncInsert, 32'h8000_0000);
  endtask

  // Deletes from the middle and from the front, so later entries move down.
  task automatic test_delete_positions();
    send_set_op(FuncDelete, 32'h0000_0000);
    send_set_op(FuncDelete, 32'h8000_0000);
  endtask

  // Fills the set, then offers a new value and a held one to the full set,
  // and finally deletes the newest entry at the tail.
  task automatic test_full_set();
    int unsigned i;
    for (i = 0; i < SetDepth - 2; i++) send_set_op(FuncInsert, 32'h5555_0000 + i * 32'h1111);
    send_set_op(FuncInsert, 32'h1234_5678);
    send_set_op(FuncInsert, 32'h7FFF_FFFF);
    send_set_op(FuncDelete, 32'h5555_0000 + (SetDepth - 3) * 32'h1111);
  endtask

  // Random traffic in phases that lean towards filling or draining the set.
  // Values come from a small pool, so duplicates, full drops and hits on
  // delete are common; a tenth of the items are noise with any value.
  task automatic test_random_traffic(input int unsigned n_items);
    logic [31:0] pool [PoolSize];
    int unsigned sent;
    int unsigned phase_left;
    int unsigned i;
    bit          filling;
    logic        func;
    logic [31:0] value;
    sent       = 0;
    phase_left = 0;
    filling    = 1'b1;
    while (sent < n_items) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(20, 60);
        for (i = 0; i < PoolSize; i++) begin
          case ($urandom_range(3))
            0:       pool[i] = 32'($urandom_range(8)) - 32'd4;
            1:       pool[i] = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                                 : 32'h7FFF_FFFF - $urandom_range(3);
            default: pool[i] = $urandom();
          endcase
        end
      end
      // The middle of the run goes without any idling on either side.
      idle_on = !(sent >= n_items / 3 && sent < n_items / 2);
      if ($urandom_range(9) == 0) begin
        func  = 1'($urandom_range(1));
        value = $urandom();
      end else begin
        func = ($urandom_range(99) < (filling ? 25 : 75)) ? FuncDelete : FuncInsert;
        if (func == FuncDelete && held_fill > 0 && $urandom_range(99) < 70) begin
          value = held_vals[$urandom_range(held_fill - 1)];
        end else begin
          value = pool[$urandom_range(PoolSize - 1)];
        end
      end
      send_set_op(func, value);
      sent++;
      phase_left--;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_set();
    test_extremes_and_dups();
    test_delete_positions();
    test_full_set();
    test_random_traffic(700);
    s_axis_tvalid_i <= 1'b0;
    while (pending_set_results.size() != 0) @(posedge clk_i);
    // Wait out the longest item, a delete on a full set; nothing more may come.
    repeat (48) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule : tb

/* sim.f */
rtl/bst_pkg.sv
rtl/bst_ram.sv
rtl/bst_scan.sv
rtl/bounded_set_table_core.sv
verif/tb.sv
